FILE: design/tcce_pkg.sv
package tcce_pkg;

    // character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_NULL    = 8'd0;

    // register indexes on the configuration port
    localparam logic REG_SCREEN_ROWS    = 1'b0;
    localparam logic REG_SCREEN_COLUMNS = 1'b1;

    // register reset values
    localparam logic [7:0] SCREEN_ROWS_RESET    = 8'd30;
    localparam logic [4:0] SCREEN_COLUMNS_RESET = 5'd1;

    // field widths
    localparam int POS_W   = 6;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 4;
    localparam int MOD_W   = 5;
    localparam int CELL_W  = 10;
    localparam int PX_W    = 13;
    localparam int PY_W    = 12;
    localparam int COLOR_W = 32;
    localparam int CODE_W  = 8;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_BLANK,
        ST_GLYPH
    } state_t;

endpackage

FILE: design/text_console_cursor_engine_top.sv
// channel | dir | tdata fields (low bit up)                         | tlast
// s_axis  | in  | char_code[7:0], color[39:8]                       | -
// m_axis  | out | pixel_x[12:0], pixel_y[24:13], glyph_color[56:25], | last
//         |     | glyph_code[64:57], zero[71:65]                     |
// apb     | in  | screen_rows at 0x0, screen_columns at 0x4          | -
//
// an ordinary character is accepted, then drawn as one glyph word
// a newline or a character at a full row blanks the next row with ROW_CHARS
// words (a character then draws its glyph); when the row index wraps, the
// compare/subtract unit first reduces the next column index one step a cycle
// every draw is one word through a single output register; a stalled
// output holds the sequencer, and s_tready is high only between items
// rst_n clears the cursor and the sequencer and resets the configuration registers at once
module text_console_cursor_engine_top #(
    parameter int ROW_CHARS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // char_code[7:0], color[39:8]
    // master side word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // pixel_x, pixel_y, glyph_color, glyph_code, zero pad
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcce_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(ROW_CHARS - 1);
    localparam logic [POS_W-1:0] FULL_POS  = POS_W'(ROW_CHARS);
    localparam logic [6:0]       ROW_PITCH = 7'(ROW_CHARS + 1);

    // configuration registers
    logic [7:0] screen_rows_reg;
    logic [4:0] screen_columns_reg;

    // cursor and sequencer
    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [MOD_W-1:0]   mod_reg, mod_next;
    logic [POS_W-1:0]   cnt_reg, cnt_next;
    logic               nl_reg, nl_next;
    logic [CODE_W-1:0]  code_reg;
    logic [COLOR_W-1:0] color_reg;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [PX_W-1:0]    px_reg, px_next;
    logic [PY_W-1:0]    py_reg, py_next;
    logic [COLOR_W-1:0] ocolor_reg, ocolor_next;
    logic [CODE_W-1:0]  ocode_reg, ocode_next;
    logic               olast_reg, olast_next;
    logic               load;

    logic [CODE_W-1:0]  in_code;
    logic [COLOR_W-1:0] in_color;
    logic               accept;
    logic               cfg_wr;
    logic               out_free;
    logic [4:0]         cols_eff;
    logic [8:0]         row_inc;
    logic [CELL_W-1:0]  col_base;
    logic [CELL_W-1:0]  cell_pos;
    logic [POS_W-1:0]   draw_pos;

    assign in_code  = s_tdata[7:0];
    assign in_color = s_tdata[39:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_SCREEN_ROWS:    prdata = {24'd0, screen_rows_reg};
            REG_SCREEN_COLUMNS: prdata = {27'd0, screen_columns_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_rows_reg    <= SCREEN_ROWS_RESET;
            screen_columns_reg <= SCREEN_COLUMNS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SCREEN_ROWS:    screen_rows_reg    <= pwdata[7:0];
                REG_SCREEN_COLUMNS: screen_columns_reg <= pwdata[4:0];
                default:            ;
            endcase
        end
    end

    // zero columns behaves as one column
    assign cols_eff = (screen_columns_reg == 5'd0) ? 5'd1 : screen_columns_reg;
    assign row_inc  = {1'b0, row_reg} + 9'd1;

    // pixel position of the drawn cell
    assign draw_pos = (state_reg == ST_BLANK) ? cnt_reg : pos_reg;
    assign col_base = CELL_W'({6'd0, col_reg} * {3'd0, ROW_PITCH});
    assign cell_pos = col_base + {{(CELL_W-POS_W){1'b0}}, draw_pos};

    // sequencer next state and draw generation
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        mod_next     = mod_reg;
        cnt_next     = cnt_reg;
        nl_next      = nl_reg;
        m_valid_next = m_valid_reg && !m_tready;
        px_next      = {cell_pos, 3'b000};
        py_next      = {row_reg, 4'b0000};
        ocolor_next  = color_reg;
        ocode_next   = code_reg;
        olast_next   = 1'b1;
        load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    nl_next  = (in_code == CHAR_NEWLINE);
                    cnt_next = '0;
                    if (in_code == CHAR_NEWLINE || pos_reg >= FULL_POS)
                    begin
                        // row advance, wrapping to the next screen column
                        pos_next = '0;
                        if (row_inc >= {1'b0, screen_rows_reg})
                        begin
                            row_next   = '0;
                            mod_next   = {1'b0, col_reg} + 5'd1;
                            state_next = ST_MOD;
                        end
                        else
                        begin
                            row_next   = row_inc[ROW_W-1:0];
                            state_next = ST_BLANK;
                        end
                    end
                    else
                    begin
                        state_next = ST_GLYPH;
                    end
                end
            end
            ST_MOD:
            begin
                // column index modulo the column count, one subtract a cycle
                if (mod_reg >= cols_eff)
                begin
                    mod_next = mod_reg - cols_eff;
                end
                else
                begin
                    col_next   = mod_reg[COL_W-1:0];
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    m_valid_next = 1'b1;
                    ocolor_next  = '0;
                    ocode_next   = CHAR_NULL;
                    olast_next   = nl_reg && (cnt_reg == LAST_POS);
                    cnt_next     = cnt_reg + POS_W'(1);
                    if (cnt_reg == LAST_POS)
                    begin
                        state_next = nl_reg ? ST_IDLE : ST_GLYPH;
                    end
                end
            end
            ST_GLYPH:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    m_valid_next = 1'b1;
                    pos_next     = pos_reg + POS_W'(1);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            mod_reg     <= '0;
            cnt_reg     <= '0;
            nl_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            mod_reg     <= mod_next;
            cnt_reg     <= cnt_next;
            nl_reg      <= nl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= in_code;
            color_reg <= in_color;
        end
        if (load)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            ocolor_reg <= ocolor_next;
            ocode_reg  <= ocode_next;
            olast_reg  <= olast_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, ocode_reg, ocolor_reg, py_reg, px_reg};
    assign m_tlast  = olast_reg;

`ifndef SYNTH
    // a newline always starts a row advance
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_code == CHAR_NEWLINE) |=> (state_reg == ST_MOD || state_reg == ST_BLANK))
    else $error("newline did not start a row advance");

    // blanking count stays inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLANK) |-> (cnt_reg < FULL_POS))
    else $error("blank counter beyond row");

    // column reduction operand never exceeds sixteen
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (mod_reg <= 5'd16))
    else $error("column reduction operand out of range");
`endif

endmodule

FILE: sim/tb_top.sv
module tb_top;

    import tcce_pkg::*;

    localparam int ROW_CHARS      = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;

    // one expected glyph draw
    typedef struct {
        logic [PX_W-1:0]    px;
        logic [PY_W-1:0]    py;
        logic [COLOR_W-1:0] color;
        logic [CODE_W-1:0]  code;
        logic               last;
    } glyph_draw_t;

    // cursor tracker and store of expected glyph draws
    class draw_scoreboard;
        glyph_draw_t    expected_draws[$];
        logic [7:0]     rows_reg;
        logic [4:0]     cols_reg;
        logic [POS_W-1:0] pos;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        int             errors;

        function new();
            rows_reg = SCREEN_ROWS_RESET;
            cols_reg = SCREEN_COLUMNS_RESET;
            pos      = '0;
            row      = '0;
            col      = '0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_SCREEN_ROWS)
                rows_reg = value[7:0];
            else
                cols_reg = value[4:0];
        endfunction

        function void push_draw(int at, logic [31:0] color, logic [7:0] code);
            glyph_draw_t d;
            int          x;
            x       = 8 * (int'(col) * (ROW_CHARS + 1) + at);
            d.px    = PX_W'(x);
            d.py    = PY_W'(16 * int'(row));
            d.color = color;
            d.code  = code;
            d.last  = 1'b0;
            expected_draws.push_back(d);
        endfunction

        // next row, wrapping into the next screen column, then blank it
        function void next_row();
            int nr;
            nr  = int'(row) + 1;
            pos = '0;
            if (nr >= int'(rows_reg))
            begin
                nr = 0;
                if (cols_reg == 0)
                    col = '0;
                else
                    col = COL_W'((int'(col) + 1) % int'(cols_reg));
            end
            row = ROW_W'(nr);
            for (int i = 0; i < ROW_CHARS; i++)
                push_draw(i, '0, CHAR_NULL);
        endfunction

        // accepted input word: work out its draws
        function void note_char(logic [7:0] code, logic [31:0] color);
            if (code == CHAR_NEWLINE)
                next_row();
            else
            begin
                if (int'(pos) >= ROW_CHARS)
                    next_row();
                push_draw(int'(pos), color, code);
                pos = pos + POS_W'(1);
            end
            expected_draws[expected_draws.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40)
                $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        endtask

        // accepted output word against the oldest expected draw
        task check_draw(logic [71:0] data, logic tlast);
            glyph_draw_t d;
            if (expected_draws.size() == 0)
            begin
                report_mismatch("unexpected draw", data[31:0], '0);
                return;
            end
            d = expected_draws.pop_front();
            if (data[12:0] != d.px)
                report_mismatch("pixel_x", 32'(data[12:0]), 32'(d.px));
            if (data[24:13] != d.py)
                report_mismatch("pixel_y", 32'(data[24:13]), 32'(d.py));
            if (data[56:25] != d.color)
                report_mismatch("glyph_color", data[56:25], d.color);
            if (data[64:57] != d.code)
                report_mismatch("glyph_code", 32'(data[64:57]), 32'(d.code));
            if (tlast != d.last)
                report_mismatch("last", 32'(tlast), 32'(d.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // char_code[7:0], color[39:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // pixel_x, pixel_y, glyph_color, glyph_code, zero pad
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    draw_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;

    // per phase: rows, columns, item count, newline share in percent
    int phase_rows[NUM_PHASES]  = '{30, 0, 1, 255, 200, 2, 4, 30};
    int phase_cols[NUM_PHASES]  = '{1, 0, 31, 16, 17, 5, 16, 1};
    int phase_items[NUM_PHASES] = '{25, 30, 50, 30, 30, 40, 40, 30};
    int phase_nl[NUM_PHASES]    = '{15, 30, 60, 20, 40, 40, 40, 15};

    text_console_cursor_engine_top #(
        .ROW_CHARS(ROW_CHARS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // offer one input word, with random gaps ahead of it
    task automatic send_word(input logic [7:0] code, input logic [31:0] color);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {color, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_char(code, color);
    endtask

    // apb write: setup, then access, then the bus goes quiet
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // let every expected draw come out before touching the registers
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_color();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // lines of random text, with bursts long enough to overflow a row
    task automatic run_text(input int items, input int nl_pct);
        int         sent;
        int         burst;
        logic [7:0] code;
        sent  = 0;
        burst = 0;
        while (sent < items)
        begin
            if (burst == 0 && $urandom_range(15) == 0)
                burst = $urandom_range(32, 40);
            if (burst == 0 && $urandom_range(99) < nl_pct)
                code = CHAR_NEWLINE;
            else
            begin
                if (burst > 0)
                    burst--;
                code = 8'($urandom_range(255));
                while (code == CHAR_NEWLINE)
                    code = 8'($urandom_range(255));
            end
            send_word(code, pick_color());
            sent++;
        end
    endtask

    // output side: check words, random stalls, long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_draw(m_tdata, m_tlast);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_request  = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 71;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, newline, row advance at reset settings
        send_word(8'h00, 32'h0000_0000);
        send_word(8'hFF, 32'hFFFF_FFFF);
        send_word(CHAR_NEWLINE, 32'h1234_5678);
        send_word(8'h41, 32'h8000_0000);
        send_word(CHAR_NEWLINE, 32'hFFFF_FFFF);
        send_word(8'h7F, 32'h0000_0001);
        send_word(8'h80, 32'h7FFF_FFFF);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 20;
            end
            if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p > 0)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
                apb_write(REG_SCREEN_ROWS,
                          ($urandom() & 32'hFFFF_FF00) | 32'(phase_rows[p]));
                apb_write(REG_SCREEN_COLUMNS,
                          ($urandom() & 32'hFFFF_FFE0) | 32'(phase_cols[p]));
            end
            // output held off while the sender keeps offering
            if (p == 3)
                hold_request = 1'b1;
            run_text(phase_items[p], phase_nl[p]);
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/tcce_pkg.sv
design/text_console_cursor_engine_top.sv
sim/tb_top.sv
